### rtl/crc8_packet_framer_core_defines.svh
// assertion macros shared by the framer modules
`ifndef CRC8_PACKET_FRAMER_CORE_DEFINES_SVH
`define CRC8_PACKET_FRAMER_CORE_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define CPF_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequence that must hold in the cycle after the trigger
`define CPF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/cpf_pkg.sv
// types, constants and crc function of the crc-8 packet framer
package cpf_pkg;

   localparam logic [7:0] CRC_POLY   = 8'h31;
   localparam logic [7:0] CRC_MSB    = 8'h80;
   localparam logic [7:0] CRC_INIT   = 8'h00;
   localparam logic [7:0] SYNC_RESET = 8'hAA;

   localparam logic ACTION_START   = 1'b0;
   localparam logic ACTION_PAYLOAD = 1'b1;

   // byte index of the trailing crc for each kind of entry
   localparam logic [2:0] HDR_CRC_IDX = 3'd4;
   localparam logic [2:0] PAY_CRC_IDX = 3'd1;

   // one queued unit of output work
   typedef struct packed {
      logic            is_header;
      logic            with_crc;
      logic [7:0]      crc;
      logic [3:0][7:0] bytes;
   } cpf_entry_type;

   // head of the work queue as seen by the back end
   typedef struct packed {
      logic          valid;
      cpf_entry_type entry;
   } cpf_head_type;

   // msb-first crc-8 update by one byte
   function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         if ((c & CRC_MSB) != 8'h00) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

### rtl/cpf_front.sv
// front end: accepts items, tracks packet state and crc, builds work entries
module cpf_front
   import cpf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write,
   input  logic [7:0]    csr_wdata,
   input  logic          req_push,
   input  logic          req_action,
   input  logic [7:0]    req_packet_type,
   input  logic [15:0]   req_payload_length,
   input  logic [7:0]   req_data_byte,
   input  logic          req_last_byte,
   input  logic          queue_full,
   output logic          queue_write,
   output cpf_entry_type queue_entry
);

   logic [7:0] sync_ff, sync_in;
   logic [7:0] crc_ff, crc_in;
   logic       in_packet_ff, in_packet_in;
   logic       accept;
   logic       len_zero;
   logic [7:0] hdr_crc;
   logic [7:0] pay_crc;

   assign accept   = req_push && !queue_full;
   assign len_zero = (req_payload_length == 16'h0000);

   // header crc over type and both length bytes, payload crc over one byte
   assign hdr_crc = crc8_fold(crc8_fold(crc8_fold(CRC_INIT, req_packet_type),
                                        req_payload_length[7:0]),
                              req_payload_length[15:8]);
   assign pay_crc = crc8_fold(crc_ff, req_data_byte);

   // classify the item and build its entry
   always_comb begin
      sync_in      = csr_write ? csr_wdata : sync_ff;
      crc_in       = crc_ff;
      in_packet_in = in_packet_ff;
      queue_write  = 1'b0;
      queue_entry  = '0;
      if (req_action == ACTION_START) begin
         queue_entry.is_header = 1'b1;
         queue_entry.with_crc  = len_zero;
         queue_entry.crc       = hdr_crc;
         queue_entry.bytes     = {req_payload_length[15:8], req_payload_length[7:0],
                                  req_packet_type, sync_ff};
         if (accept) begin
            queue_write  = 1'b1;
            crc_in       = hdr_crc;
            in_packet_in = !len_zero;
         end
      end else begin
         queue_entry.is_header = 1'b0;
         queue_entry.with_crc  = req_last_byte;
         queue_entry.crc       = pay_crc;
         queue_entry.bytes     = {24'h000000, req_data_byte};
         // payload outside a packet is dropped without any transfer out
         if (accept && in_packet_ff) begin
            queue_write  = 1'b1;
            crc_in       = pay_crc;
            in_packet_in = !req_last_byte;
         end
      end
   end

   // packet state and sync register
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff      <= SYNC_RESET;
         crc_ff       <= CRC_INIT;
         in_packet_ff <= 1'b0;
      end else begin
         sync_ff      <= sync_in;
         crc_ff       <= crc_in;
         in_packet_ff <= in_packet_in;
      end
   end

endmodule

### rtl/cpf_queue.sv
// work queue between front end and back end
`include "crc8_packet_framer_core_defines.svh"
module cpf_queue
   import cpf_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          write_en,
   input  cpf_entry_type write_entry,
   input  logic          read_en,
   output logic          full,
   output cpf_head_type  head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cpf_entry_type          slots_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_read;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = slots_ff[rd_ptr_ff];
   assign do_read    = read_en && head.valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (write_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_read) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({write_en, do_read})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (write_en) begin
         slots_ff[wr_ptr_ff] <= write_entry;
      end
   end

   `CPF_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(DEPTH), "queue count above depth")
   `CPF_ASSERT_ALWAYS(a_no_write_full, !(write_en && full), "queue written while full")
   `CPF_ASSERT_NEXT(a_count_up, write_en && !do_read, count_ff == $past(count_ff) + 1'b1,
                    "queue count did not grow on write")

endmodule

### rtl/cpf_back.sv
// back end: serializes queued entries into bytes through the output register
`include "crc8_packet_framer_core_defines.svh"
module cpf_back
   import cpf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cpf_head_type head,
   output logic         queue_read,
   input  logic         rsp_pop,
   output logic         rsp_empty,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_is_crc,
   output logic         rsp_end_of_run
);

   logic [2:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_crc_ff, out_crc_in;
   logic       out_end_ff, out_end_in;
   logic       slot_free;
   logic       emit;
   logic [2:0] crc_idx;
   logic [2:0] last_idx;
   logic       at_crc;
   logic       at_last;

   assign slot_free = !out_valid_ff || rsp_pop;
   assign emit      = slot_free && head.valid;

   // position of the crc and of the final byte for the head entry
   assign crc_idx  = head.entry.is_header ? HDR_CRC_IDX : PAY_CRC_IDX;
   assign last_idx = head.entry.with_crc ? crc_idx : crc_idx - 1'b1;
   assign at_crc   = head.entry.with_crc && (idx_ff == crc_idx);
   assign at_last  = (idx_ff == last_idx);

   assign queue_read = emit && at_last;

   // byte selection and output register load
   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_byte_in  = out_byte_ff;
      out_crc_in   = out_crc_ff;
      out_end_in   = out_end_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = at_crc ? head.entry.crc : head.entry.bytes[idx_ff[1:0]];
         out_crc_in   = at_crc;
         out_end_in   = at_last;
         idx_in       = at_last ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_crc_ff  <= out_crc_in;
      out_end_ff  <= out_end_in;
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_is_crc     = out_crc_ff;
   assign rsp_end_of_run = out_end_ff;

   `CPF_ASSERT_ALWAYS(a_mid_entry_head, (idx_ff == 3'd0) || head.valid,
                      "serializer mid entry with empty queue")
   `CPF_ASSERT_ALWAYS(a_idx_bound, !head.valid || (idx_ff <= last_idx),
                      "serializer index past last byte")
   `CPF_ASSERT_NEXT(a_crc_ends_run, emit && at_crc, out_crc_ff && out_end_ff,
                    "crc byte not flagged as end of run")

endmodule

### rtl/crc8_packet_framer_core.sv
// top level of the crc-8 packet framer
// Framer that wraps payload bytes between a sync/type/length header and a
// trailing CRC-8 (poly 0x31, msb first, init 0, covering type, length and
// payload). A start item yields four result bytes, five when its length is
// zero; a payload item yields one byte, two when flagged last; payload items
// outside a packet are dropped. The front end takes one item per cycle while
// the work queue (QUEUE_DEPTH entries) has room; the back end serializer emits
// one result byte per cycle while its output register is empty or popped, so
// a stream of payload bytes runs at one item per cycle when rsp_pop keeps up.
// The first result passes the work queue, then the output register. sync_byte
// is written through csr_write/csr_wdata and resets to 0xAA.
module crc8_packet_framer_core
   import cpf_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [7:0]  csr_wdata,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_action,
   input  logic [7:0]  req_packet_type,
   input  logic [15:0] req_payload_length,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_is_crc,
   output logic        rsp_end_of_run
);

   logic          queue_write;
   logic          queue_read;
   cpf_entry_type queue_entry;
   cpf_head_type  queue_head;

   // front end
   cpf_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_wdata          (csr_wdata),
      .req_push           (req_push),
      .req_action         (req_action),
      .req_packet_type    (req_packet_type),
      .req_payload_length (req_payload_length),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .queue_full         (req_full),
      .queue_write        (queue_write),
      .queue_entry        (queue_entry)
   );

   // work queue
   cpf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .write_en    (queue_write),
      .write_entry (queue_entry),
      .read_en     (queue_read),
      .full        (req_full),
      .head        (queue_head)
   );

   // back end
   cpf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (queue_head),
      .queue_read     (queue_read),
      .rsp_pop        (rsp_pop),
      .rsp_empty      (rsp_empty),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_crc     (rsp_is_crc),
      .rsp_end_of_run (rsp_end_of_run)
   );

endmodule
